@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page run allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPRA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication
`define TPRA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/tpra_pkg.sv @@
// ----------------------------------------------------------------------------
// tpra_pkg
// Types, constants and helpers of the two-pool page run allocator.
// ----------------------------------------------------------------------------
package tpra_pkg;

    localparam int POOL_PAGES = 1024;
    localparam int PAGE_W     = 36;
    localparam int CNT_W      = 11;
    localparam int IDX_W      = $clog2(POOL_PAGES);
    localparam int WORD_W     = 32;
    localparam int OFF_W      = $clog2(WORD_W);
    localparam int WORDS      = POOL_PAGES / WORD_W;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int CHUNK      = 8;
    localparam int CHUNK_W    = $clog2(CHUNK);
    localparam int CSEL_W     = $clog2(WORD_W / CHUNK);
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KBASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KTOTAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UBASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UTOTAL = 2'd3;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGES = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;
    localparam logic [1:0] ST_NOT_USED = 2'd3;

    typedef struct packed {
        logic              command;
        logic              from_user_pool;
        logic              panic_on_fail;
        logic [CNT_W-1:0]  page_count;
        logic [PAGE_W-1:0] page_number;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] granted_page;
        logic              panic;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       alloc_setup;
        logic       free_setup;
        logic       rmw_setup;
        logic       rmw_set;
        logic       scan_step;
        logic       next_word;
        logic       rmw_check;
        logic       rmw_write;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_grant;
        logic       res_panic;
        logic       out_load;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
        logic is_free;
        logic page_zero;
        logic too_big;
        logic hit_any;
        logic fits;
        logic scan_hit;
        logic chunk_last;
        logic scan_end;
        logic rmw_last;
        logic rmw_bad;
        logic out_free;
    } dp_stat_t;

    // page total saturates at the pool capacity
    function automatic logic [CNT_W-1:0] pool_size(input logic [CNT_W-1:0] total);
        if (total > CNT_W'(POOL_PAGES)) begin
            return CNT_W'(POOL_PAGES);
        end
        return total;
    endfunction

endpackage

@@ sv/two_pool_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// two_pool_page_run_allocator
// First-fit bitmap page allocator with a kernel pool and a user pool.
// ----------------------------------------------------------------------------
//  channel   ports                          moves
//  s_        s_valid / s_ready / s_item     request item (allocate or free)
//  m_        m_valid / m_ready / m_item     result item, one per request
//  cfg_      cfg_wr_en / cfg_index / data   pool base and size registers
//
//  One item at a time. Allocate reads each bitmap word and scans it in four
//  8-page steps, then marks each word of the run with a read and a write.
//  Free reads and checks each word of the range, then reads and clears each.
//  Bitmaps are all-used after reset through per-word valid flops; no sweep.
//  The next item is taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module two_pool_page_run_allocator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [tpra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpra_pkg::PAGE_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tpra_pkg::in_item_t             s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tpra_pkg::out_item_t            m_item
);
    import tpra_pkg::*;

`include "assert_macros.svh"

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // sequencer
    tpra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // bitmaps, scanner and result register
    tpra_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_item    (m_item),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a granted page only comes with an ok status
    `TPRA_ASSERT_IMP(a_grant_ok, aclk, aresetn,
        m_valid && (m_item.status != ST_OK), m_item.granted_page == '0)
    // panic only on an out-of-pages result
    `TPRA_ASSERT_IMP(a_panic_nop, aclk, aresetn,
        m_valid && m_item.panic, m_item.status == ST_NO_PAGES)
    // one item in flight: an accepted item closes the input
    `TPRA_ASSERT_NXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

@@ sv/tpra_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpra_ctrl
// Sequencer for allocate and free items: decode, scan, check, mark or clear, result.
// ----------------------------------------------------------------------------
module tpra_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tpra_pkg::dp_stat_t stat,
    output tpra_pkg::ctl_cmd_t cmd
);
    import tpra_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_FFIT = 4'd2;
    localparam logic [3:0] S_ACHK = 4'd3;
    localparam logic [3:0] S_SRD  = 4'd4;
    localparam logic [3:0] S_SCHK = 4'd5;
    localparam logic [3:0] S_MSET = 4'd6;
    localparam logic [3:0] S_CRD  = 4'd7;
    localparam logic [3:0] S_CDO  = 4'd8;
    localparam logic [3:0] S_WRD  = 4'd9;
    localparam logic [3:0] S_WDO  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                if (stat.cnt_zero || (stat.is_free && stat.page_zero)) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_FIN;
                end else if (stat.is_free) begin
                    cmd.free_setup = 1'b1;
                    state_next     = S_FFIT;
                end else begin
                    cmd.alloc_setup = 1'b1;
                    state_next      = S_ACHK;
                end
            end
            S_FFIT: begin
                if (!stat.hit_any || !stat.fits) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OUTSIDE;
                    state_next     = S_FIN;
                end else begin
                    cmd.rmw_setup = 1'b1;
                    state_next    = S_CRD;
                end
            end
            S_ACHK: begin
                if (stat.too_big) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_NO_PAGES;
                    cmd.res_panic  = 1'b1;
                    state_next     = S_FIN;
                end else begin
                    state_next = S_SRD;
                end
            end
            S_SRD: state_next = S_SCHK;
            S_SCHK: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit) begin
                    state_next = S_MSET;
                end else if (stat.chunk_last) begin
                    if (stat.scan_end) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NO_PAGES;
                        cmd.res_panic  = 1'b1;
                        state_next     = S_FIN;
                    end else begin
                        cmd.next_word = 1'b1;
                        state_next    = S_SRD;
                    end
                end
            end
            S_MSET: begin
                cmd.rmw_setup = 1'b1;
                cmd.rmw_set   = 1'b1;
                state_next    = S_WRD;
            end
            S_CRD: state_next = S_CDO;
            S_CDO: begin
                if (stat.rmw_last) begin
                    if (stat.rmw_bad) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_NOT_USED;
                        state_next     = S_FIN;
                    end else begin
                        cmd.rmw_setup = 1'b1;
                        state_next    = S_WRD;
                    end
                end else begin
                    cmd.rmw_check = 1'b1;
                    cmd.next_word = 1'b1;
                    state_next    = S_CRD;
                end
            end
            S_WRD: state_next = S_WDO;
            S_WDO: begin
                cmd.rmw_write = 1'b1;
                if (stat.rmw_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_grant  = !stat.is_free;
                    state_next     = S_FIN;
                end else begin
                    cmd.next_word = 1'b1;
                    state_next    = S_WRD;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/tpra_dp.sv @@
// ----------------------------------------------------------------------------
// tpra_dp
// Registers, bitmap memory, run scanner and range mark/check logic.
// ----------------------------------------------------------------------------
module tpra_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tpra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpra_pkg::PAGE_W-1:0]   cfg_wdata,
    input  tpra_pkg::in_item_t            s_item,
    input  logic                          m_ready,
    output logic                          m_valid,
    output tpra_pkg::out_item_t           m_item,
    input  tpra_pkg::ctl_cmd_t            cmd,
    output tpra_pkg::dp_stat_t            stat
);
    import tpra_pkg::*;

    // configuration
    logic [PAGE_W-1:0] kbase_reg, ubase_reg;
    logic [CNT_W-1:0]  ktotal_reg, utotal_reg;

    // item and working registers
    in_item_t            item_reg;
    logic                pool_reg;
    logic [CNT_W-1:0]    size_reg;
    logic [PAGE_W-1:0]   base_reg;
    logic [IDX_W-1:0]    start_reg;
    logic [CNT_W:0]      end_reg;
    logic                hit_reg;
    logic [WADDR_W-1:0]  wptr_reg;
    logic [CSEL_W-1:0]   chunk_reg;
    logic [CNT_W-1:0]    run_reg;
    logic                set_reg;
    logic                bad_reg;
    logic [1:0]          res_status_reg;
    logic                res_grant_reg;
    logic                res_panic_reg;
    out_item_t           out_reg;
    logic                m_valid_reg;

    // bitmap store: both pools, a row valid bit reads unwritten rows as all used
    logic [WORD_W-1:0]   mem [2*WORDS];
    logic [2*WORDS-1:0]  row_valid_reg;
    logic [WORD_W-1:0]   rd_raw_reg;
    logic                rd_valid_reg;
    logic [WADDR_W:0]    addr;
    logic [WORD_W-1:0]   word;

    assign addr = {pool_reg, wptr_reg};
    assign word = rd_valid_reg ? rd_raw_reg : '1;

    // free lookup
    logic [CNT_W-1:0]  ksize, usize;
    logic              k_hit, u_hit;
    logic [PAGE_W-1:0] page;

    assign page  = item_reg.page_number;
    assign ksize = pool_size(ktotal_reg);
    assign usize = pool_size(utotal_reg);
    assign k_hit = (page >= kbase_reg) &&
                   ({1'b0, page} < ({1'b0, kbase_reg} + (PAGE_W+1)'(ksize)));
    assign u_hit = (page >= ubase_reg) &&
                   ({1'b0, page} < ({1'b0, ubase_reg} + (PAGE_W+1)'(usize)));

    // run scan over one chunk of the current word
    logic [CHUNK-1:0] cbits;
    logic [CNT_W-1:0] run_v, idx_v, g;
    logic             hit_v, used;

    assign cbits = word[chunk_reg*CHUNK +: CHUNK];

    always_comb begin
        run_v = run_reg;
        hit_v = 1'b0;
        idx_v = '0;
        g     = '0;
        used  = 1'b0;
        for (int k = 0; k < CHUNK; k++) begin
            g    = CNT_W'({wptr_reg, chunk_reg, CHUNK_W'(0)}) + CNT_W'(k);
            used = cbits[k] || (g >= size_reg);
            if (!hit_v) begin
                if (used) begin
                    run_v = '0;
                end else begin
                    run_v = run_v + CNT_W'(1);
                    if (run_v == item_reg.page_count) begin
                        hit_v = 1'b1;
                        idx_v = g + CNT_W'(1) - item_reg.page_count;
                    end
                end
            end
        end
    end

    // range mask of the current word
    logic [WORD_W-1:0] mask;
    logic [CNT_W:0]    gm;
    logic [CNT_W:0]    end_m1;
    logic [CNT_W:0]    next_base;

    always_comb begin
        mask = '0;
        gm   = '0;
        for (int j = 0; j < WORD_W; j++) begin
            gm      = (CNT_W+1)'({wptr_reg, OFF_W'(j)});
            mask[j] = (gm >= (CNT_W+1)'(start_reg)) && (gm < end_reg);
        end
    end

    assign end_m1    = end_reg - (CNT_W+1)'(1);
    assign next_base = (CNT_W+1)'({(WADDR_W+1)'(wptr_reg) + (WADDR_W+1)'(1), OFF_W'(0)});

    // status to the controller
    always_comb begin
        stat.cnt_zero   = (item_reg.page_count == '0);
        stat.is_free    = (item_reg.command == CMD_FREE);
        stat.page_zero  = (page == '0);
        stat.too_big    = (item_reg.page_count > size_reg);
        stat.hit_any    = hit_reg;
        stat.fits       = ((CNT_W+1)'(start_reg) + (CNT_W+1)'(item_reg.page_count))
                          <= (CNT_W+1)'(size_reg);
        stat.scan_hit   = hit_v;
        stat.chunk_last = (chunk_reg == '1);
        stat.scan_end   = (next_base >= (CNT_W+1)'(size_reg));
        stat.rmw_last   = (wptr_reg == end_m1[IDX_W-1:OFF_W]);
        stat.rmw_bad    = bad_reg || ((word & mask) != mask);
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // memory
    always_ff @(posedge aclk) begin
        rd_raw_reg <= mem[addr];
        if (cmd.rmw_write) begin
            mem[addr] <= set_reg ? (word | mask) : (word & ~mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= row_valid_reg[addr];
            if (cmd.rmw_write) begin
                row_valid_reg[addr] <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbase_reg  <= '0;
            ktotal_reg <= '0;
            ubase_reg  <= '0;
            utotal_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_KBASE:  kbase_reg  <= cfg_wdata;
                CFG_KTOTAL: ktotal_reg <= cfg_wdata[CNT_W-1:0];
                CFG_UBASE:  ubase_reg  <= cfg_wdata;
                CFG_UTOTAL: utotal_reg <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.alloc_setup) begin
            pool_reg  <= item_reg.from_user_pool;
            size_reg  <= item_reg.from_user_pool ? usize : ksize;
            base_reg  <= item_reg.from_user_pool ? ubase_reg : kbase_reg;
            wptr_reg  <= '0;
            chunk_reg <= '0;
            run_reg   <= '0;
        end
        if (cmd.free_setup) begin
            hit_reg   <= k_hit || u_hit;
            pool_reg  <= !k_hit;
            size_reg  <= k_hit ? ksize : usize;
            base_reg  <= k_hit ? kbase_reg : ubase_reg;
            start_reg <= k_hit ? IDX_W'(page - kbase_reg) : IDX_W'(page - ubase_reg);
        end
        if (cmd.scan_step) begin
            chunk_reg <= chunk_reg + CSEL_W'(1);
            run_reg   <= run_v;
            if (hit_v) begin
                start_reg <= idx_v[IDX_W-1:0];
            end
        end
        if (cmd.rmw_check) begin
            bad_reg <= stat.rmw_bad;
        end
        if (cmd.next_word) begin
            wptr_reg <= wptr_reg + WADDR_W'(1);
        end
        if (cmd.rmw_setup) begin
            wptr_reg <= start_reg[IDX_W-1:OFF_W];
            end_reg  <= (CNT_W+1)'(start_reg) + (CNT_W+1)'(item_reg.page_count);
            set_reg  <= cmd.rmw_set;
            bad_reg  <= 1'b0;
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= cmd.res_grant;
            res_panic_reg  <= cmd.res_panic && item_reg.panic_on_fail;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.status       <= res_status_reg;
            out_reg.granted_page <= res_grant_reg ?
                                    (base_reg + PAGE_W'(start_reg)) : '0;
            out_reg.panic        <= res_panic_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule
